// ===== rtl/core/pidaw_pkg.sv =====
`timescale 1ns / 1ps
package pidaw_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned InTdataW = 80;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned StepW    = 5;
  localparam int unsigned MagW     = 33;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned AccW     = 80;
  localparam int unsigned DivW     = 64;
  localparam int unsigned DivDigit = 4;
  localparam int unsigned DivCntW  = $clog2(DivW / DivDigit + 1);
  localparam int unsigned IncW     = 56;
  localparam int unsigned TotW     = 34;

  // Integral divisor after the Q16.16 shift: 2 * 1000 ms per second.
  localparam logic [MsW-1:0]  IntegDivisor = MsW'(2000);
  localparam logic [MagW-1:0] DerivScale   = MagW'(1000);

  localparam logic [RegIdxW-1:0] RegGainP    = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegGainI    = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegGainD    = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] RegOutMin   = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] RegOutMax   = RegIdxW'(4);
  localparam logic [RegIdxW-1:0] RegIntegMin = RegIdxW'(5);
  localparam logic [RegIdxW-1:0] RegIntegMax = RegIdxW'(6);

  typedef enum logic [1:0] {XS_NONE, XS_ESUM, XS_DIFF} xsel_e;
  typedef enum logic [1:0] {MG_NONE, MG_P, MG_I, MG_D} magsel_e;
  typedef enum logic [2:0] {
    MU_NONE, MU_KX, MU_HI_MS, MU_LO_MS, MU_HI_K1000, MU_LO_K1000
  } mulsel_e;
  typedef enum logic [1:0] {AC_NONE, AC_LOAD, AC_SHADD, AC_MLOAD} accop_e;
  typedef enum logic [1:0] {DV_NONE, DV_INTEG, DV_DERIV} divop_e;
  typedef enum logic [2:0] {
    RS_NONE, RS_ERR, RS_PROP, RS_INC, RS_DERIV, RS_DRIVE
  } resop_e;
  typedef enum logic [1:0] {NX_STEP, NX_WAIT_DIV, NX_END} nxt_e;

  typedef struct packed {
    xsel_e   xsel;
    magsel_e mag;
    mulsel_e mul;
    accop_e  acc;
    divop_e  div;
    resop_e  res;
    nxt_e    nxt;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   en;
    ucode_t uc;
  } dp_ctrl_t;

  typedef struct packed {
    logic div_busy;
  } dp_stat_t;

  typedef struct packed {
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
    logic signed [DataW-1:0] integ_min;
    logic signed [DataW-1:0] integ_max;
  } cfg_t;

  localparam logic signed [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};

  localparam cfg_t CfgReset = '{
    gain_p: '0, gain_i: '0, gain_d: '0,
    out_min: SMin, out_max: SMax, integ_min: SMin, integ_max: SMax
  };

  localparam ucode_t UcNop = '{
    xsel: XS_NONE, mag: MG_NONE, mul: MU_NONE, acc: AC_NONE,
    div: DV_NONE, res: RS_NONE, nxt: NX_STEP
  };

  // Microprogram: proportional term, integral increment, derivative, sum.
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t uc;
    uc = UcNop;
    case (step)
      StepW'(0): uc.res = RS_ERR;
      StepW'(1): begin
        uc.mag  = MG_P;
        uc.xsel = XS_ESUM;
      end
      StepW'(2): uc.mul = MU_KX;
      StepW'(3): begin
        uc.res = RS_PROP;
        uc.mag = MG_I;
      end
      StepW'(4): uc.mul = MU_KX;
      StepW'(5): uc.acc = AC_MLOAD;
      StepW'(6): uc.mul = MU_HI_MS;
      StepW'(7): begin
        uc.mul = MU_LO_MS;
        uc.acc = AC_LOAD;
      end
      StepW'(8): uc.acc = AC_SHADD;
      StepW'(9): begin
        uc.div  = DV_INTEG;
        uc.xsel = XS_DIFF;
      end
      StepW'(10): begin
        uc.mag = MG_D;
        uc.nxt = NX_WAIT_DIV;
      end
      StepW'(11): begin
        uc.res = RS_INC;
        uc.mul = MU_KX;
      end
      StepW'(12): uc.acc = AC_MLOAD;
      StepW'(13): uc.mul = MU_HI_K1000;
      StepW'(14): begin
        uc.mul = MU_LO_K1000;
        uc.acc = AC_LOAD;
      end
      StepW'(15): uc.acc = AC_SHADD;
      StepW'(16): uc.div = DV_DERIV;
      StepW'(17): uc.nxt = NX_WAIT_DIV;
      StepW'(18): uc.res = RS_DERIV;
      StepW'(19): begin
        uc.res = RS_DRIVE;
        uc.nxt = NX_END;
      end
      default: uc.nxt = NX_END;
    endcase
    return uc;
  endfunction

endpackage

// ===== rtl/core/pidaw_datapath.sv =====
`timescale 1ns / 1ps
module pidaw_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pidaw_pkg::dp_ctrl_t                 ctrl_i,
  input  pidaw_pkg::cfg_t                     cfg_i,
  input  logic signed [pidaw_pkg::DataW-1:0]  target_i,
  input  logic signed [pidaw_pkg::DataW-1:0]  sensed_i,
  input  logic        [pidaw_pkg::MsW-1:0]    elapsed_ms_i,
  output pidaw_pkg::dp_stat_t                 stat_o,
  output logic signed [pidaw_pkg::DataW-1:0]  drive_o
);
  import pidaw_pkg::*;

  localparam logic [ProdW-1:0] MagPos = ProdW'(SMax);
  localparam logic [ProdW-1:0] MagNeg = MagPos + ProdW'(1);

  // Saturating conversion of a magnitude and a sign to a signed word.
  function automatic logic signed [DataW-1:0] sat_mag(input logic [ProdW-1:0] m,
                                                      input logic neg);
    logic signed [DataW-1:0] r;
    if (neg) begin
      if (m > MagNeg) r = SMin;
      else r = $signed(-m[DataW-1:0]);
    end else begin
      if (m > MagPos) r = SMax;
      else r = $signed(m[DataW-1:0]);
    end
    return r;
  endfunction

  ucode_t uc;
  logic   en;

  // Item and history
  logic signed [DataW-1:0] tgt_q, sns_q, err_q;
  logic        [MsW-1:0]   ms_q;
  logic signed [DataW-1:0] integ_q, integ_d, last_err_q, last_sns_q;
  logic signed [DataW-1:0] prop_q, deriv_q, drive_q, drive_d, err_d;

  // Operands and products
  logic signed [MagW-1:0]  x_q, x_d, xsrc;
  logic signed [DataW-1:0] ksrc;
  logic        [DataW-1:0] kmag_q;
  logic        [MagW-1:0]  xmag_q;
  logic                    neg_p_q, neg_i_q, neg_d_q, neg_new;
  logic        [MagW-1:0]  mul_a, mul_b;
  logic        [2*MagW-1:0] mul_full;
  logic        [ProdW-1:0] prod_q, m_q;
  logic        [AccW-1:0]  acc_q;

  // Divider
  logic [DivW-1:0]    dvd_q, dv_q;
  logic [MsW-1:0]     dvs_q, rem_q, dv_r;
  logic [MsW:0]       dv_t;
  logic [DivCntW-1:0] cnt_q;

  // Result arithmetic
  logic signed [MagW-1:0] ediff;
  logic signed [IncW-1:0] inc_mag, inc_s, isum;
  logic signed [TotW-1:0] dsum;

  assign uc = ctrl_i.uc;
  assign en = ctrl_i.en;

  always_comb begin
    ediff = MagW'(tgt_q) - MagW'(sns_q);
    if (ediff[MagW-1] != ediff[MagW-2]) err_d = ediff[MagW-1] ? SMin : SMax;
    else err_d = $signed(ediff[DataW-1:0]);

    case (uc.xsel)
      XS_ESUM: x_d = MagW'(err_q) + MagW'(last_err_q);
      XS_DIFF: x_d = MagW'(sns_q) - MagW'(last_sns_q);
      default: x_d = x_q;
    endcase

    case (uc.mag)
      MG_P:    ksrc = cfg_i.gain_p;
      MG_I:    ksrc = cfg_i.gain_i;
      MG_D:    ksrc = cfg_i.gain_d;
      default: ksrc = cfg_i.gain_p;
    endcase
    xsrc    = (uc.mag == MG_P) ? MagW'(err_q) : x_q;
    neg_new = ksrc[DataW-1] ^ xsrc[MagW-1];

    case (uc.mul)
      MU_KX: begin
        mul_a = {1'b0, kmag_q};
        mul_b = xmag_q;
      end
      MU_HI_MS: begin
        mul_a = {1'b0, m_q[ProdW-1:DataW]};
        mul_b = MagW'(ms_q);
      end
      MU_LO_MS: begin
        mul_a = {1'b0, m_q[DataW-1:0]};
        mul_b = MagW'(ms_q);
      end
      MU_HI_K1000: begin
        mul_a = {1'b0, m_q[ProdW-1:DataW]};
        mul_b = DerivScale;
      end
      MU_LO_K1000: begin
        mul_a = {1'b0, m_q[DataW-1:0]};
        mul_b = DerivScale;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_full = (2*MagW)'(mul_a) * (2*MagW)'(mul_b);

    // The quotient of the integral division stays well below 2^53.
    inc_mag = $signed({1'b0, dvd_q[IncW-2:0]});
    inc_s   = neg_i_q ? -inc_mag : inc_mag;
    isum    = IncW'(integ_q) + inc_s;
    if (isum > IncW'(cfg_i.integ_max)) integ_d = cfg_i.integ_max;
    else if (isum < IncW'(cfg_i.integ_min)) integ_d = cfg_i.integ_min;
    else integ_d = $signed(isum[DataW-1:0]);

    dsum = TotW'(prop_q) + TotW'(integ_q) + TotW'(deriv_q);
    if (dsum > TotW'(cfg_i.out_max)) drive_d = cfg_i.out_max;
    else if (dsum < TotW'(cfg_i.out_min)) drive_d = cfg_i.out_min;
    else drive_d = $signed(dsum[DataW-1:0]);
  end

  // Restoring division, four quotient bits a cycle; the dividend register
  // fills up with the quotient from the bottom.
  always_comb begin
    dv_r = rem_q;
    dv_q = dvd_q;
    dv_t = '0;
    for (int j = 0; j < DivDigit; j++) begin
      dv_t = {dv_r, dv_q[DivW-1]};
      dv_q = {dv_q[DivW-2:0], 1'b0};
      if (dv_t >= {1'b0, dvs_q}) begin
        dv_t    = dv_t - {1'b0, dvs_q};
        dv_q[0] = 1'b1;
      end
      dv_r = dv_t[MsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
      last_sns_q <= '0;
      cnt_q      <= '0;
    end else begin
      if (en && uc.res == RS_INC) integ_q <= integ_d;
      if (en && uc.res == RS_DRIVE) begin
        last_err_q <= err_q;
        last_sns_q <= sns_q;
      end
      if (en && uc.div != DV_NONE) cnt_q <= DivCntW'(DivW / DivDigit);
      else if (cnt_q != '0) cnt_q <= cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      tgt_q <= target_i;
      sns_q <= sensed_i;
      ms_q  <= (elapsed_ms_i == '0) ? MsW'(1) : elapsed_ms_i;
    end
    if (en) begin
      x_q <= x_d;
      if (uc.res == RS_ERR) err_q <= err_d;
      if (uc.mag != MG_NONE) begin
        kmag_q <= ksrc[DataW-1] ? $unsigned(-ksrc) : $unsigned(ksrc);
        xmag_q <= xsrc[MagW-1] ? $unsigned(-xsrc) : $unsigned(xsrc);
      end
      if (uc.mag == MG_P) neg_p_q <= neg_new;
      if (uc.mag == MG_I) neg_i_q <= neg_new;
      // The derivative is taken negated.
      if (uc.mag == MG_D) neg_d_q <= !neg_new;
      if (uc.mul != MU_NONE) prod_q <= mul_full[ProdW-1:0];
      case (uc.acc)
        AC_LOAD:  acc_q <= AccW'(prod_q);
        AC_SHADD: acc_q <= {acc_q[AccW-DataW-1:0], {DataW{1'b0}}} + AccW'(prod_q);
        AC_MLOAD: m_q   <= prod_q;
        default:  ;
      endcase
      if (uc.res == RS_PROP) prop_q <= sat_mag({16'b0, prod_q[ProdW-1:16]}, neg_p_q);
      if (uc.res == RS_DERIV) deriv_q <= sat_mag(dvd_q, neg_d_q);
      if (uc.res == RS_DRIVE) drive_q <= drive_d;
    end
    if (en && uc.div != DV_NONE) begin
      dvd_q <= acc_q[AccW-1:AccW-DivW];
      dvs_q <= (uc.div == DV_INTEG) ? IntegDivisor : ms_q;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= dv_q;
      rem_q <= dv_r;
    end
  end

  assign stat_o.div_busy = (cnt_q != '0);
  assign drive_o         = drive_q;

endmodule

// ===== rtl/core/pid_controller_antiwindup.sv =====
`timescale 1ns / 1ps
// An output beat follows an accepted input beat after 20 microcode steps, two of
// them waiting on a division in the shared divider.
// The divider works four quotient bits a cycle. An item is taken only once the
// previous one has run its steps; a new beat is taken while the previous result waits.
// Reset (rst_ni low, asynchronous) clears the sequencer, the output valid, the
// integrator and the error and measurement history, and loads the default limits.
module pid_controller_antiwindup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // target [31:0], sensed [63:32], elapsed_ms [79:64]
  input  logic [pidaw_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // drive [31:0]
  output logic [pidaw_pkg::DataW-1:0]         m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]         paddr,
  input  logic [pidaw_pkg::DataW-1:0]         pwdata,
  output logic [pidaw_pkg::DataW-1:0]         prdata,
  output logic                                pready
);
  import pidaw_pkg::*;

  cfg_t                 cfg_q;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 cfg_wr;

  logic                 run_q, run_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 step_en, out_free, in_acc;
  ucode_t               uc;
  dp_ctrl_t             ctrl;
  dp_stat_t             stat;
  logic signed [DataW-1:0] drive;

  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegGainP:    cfg_q.gain_p    <= $signed(pwdata);
        RegGainI:    cfg_q.gain_i    <= $signed(pwdata);
        RegGainD:    cfg_q.gain_d    <= $signed(pwdata);
        RegOutMin:   cfg_q.out_min   <= $signed(pwdata);
        RegOutMax:   cfg_q.out_max   <= $signed(pwdata);
        RegIntegMin: cfg_q.integ_min <= $signed(pwdata);
        RegIntegMax: cfg_q.integ_max <= $signed(pwdata);
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegGainP:    prdata = $unsigned(cfg_q.gain_p);
      RegGainI:    prdata = $unsigned(cfg_q.gain_i);
      RegGainD:    prdata = $unsigned(cfg_q.gain_d);
      RegOutMin:   prdata = $unsigned(cfg_q.out_min);
      RegOutMax:   prdata = $unsigned(cfg_q.out_max);
      RegIntegMin: prdata = $unsigned(cfg_q.integ_min);
      RegIntegMax: prdata = $unsigned(cfg_q.integ_max);
      default:     prdata = '0;
    endcase
  end

  // Sequencer: one control word a step; wait steps hold until their condition clears.
  always_comb begin
    uc       = ucode_rom(step_q);
    out_free = !out_valid_q || m_axis_tready;
    in_acc   = s_axis_tvalid && !run_q;
    case (uc.nxt)
      NX_STEP:     step_en = run_q;
      NX_WAIT_DIV: step_en = run_q && !stat.div_busy;
      NX_END:      step_en = run_q && out_free;
      default:     step_en = 1'b0;
    endcase

    run_d  = run_q;
    step_d = step_q;
    if (in_acc) begin
      run_d  = 1'b1;
      step_d = '0;
    end else if (step_en) begin
      if (uc.nxt == NX_END) begin
        run_d  = 1'b0;
        step_d = '0;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end

    out_valid_d = out_valid_q && !m_axis_tready;
    if (step_en && uc.nxt == NX_END) out_valid_d = 1'b1;

    ctrl = '{load: in_acc, en: step_en, uc: uc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  pidaw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_q),
    .target_i     ($signed(s_axis_tdata[31:0])),
    .sensed_i     ($signed(s_axis_tdata[63:32])),
    .elapsed_ms_i (s_axis_tdata[79:64]),
    .stat_o       (stat),
    .drive_o      (drive)
  );

  assign s_axis_tready = !run_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = $unsigned(drive);

endmodule

// ===== rtl/core/pidaw_sva.sv =====
`timescale 1ns / 1ps
module pidaw_sva (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pidaw_pkg::DataW-1:0]    m_axis_tdata
);

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // A result never appears on the cycle straight after an input beat.
  a_no_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result raised too early");

  // A finished item frees the input side in the same cycle as its result shows.
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input side still busy when the result appeared");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

endmodule

bind pid_controller_antiwindup pidaw_sva u_pidaw_sva (.*);
